@@ rtl/core/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

  localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
  localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;
  localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
  localparam logic [20:0] PLANE_BASE  = 21'h010000;
  localparam logic [15:0] HI_SURR     = 16'hD800;
  localparam logic [15:0] LO_SURR     = 16'hDC00;
  localparam logic [7:0]  MASK_LEAD2  = 8'hE0;
  localparam logic [7:0]  MASK_LEAD3  = 8'hF0;
  localparam logic [7:0]  MASK_LEAD4  = 8'hF8;
  localparam logic [7:0]  MASK_CONT   = 8'hC0;
  localparam logic [7:0]  CODE_LEAD2  = 8'hC0;
  localparam logic [7:0]  CODE_LEAD3  = 8'hE0;
  localparam logic [7:0]  CODE_LEAD4  = 8'hF0;
  localparam logic [7:0]  CODE_CONT   = 8'h80;
  localparam logic [15:0] MAX_UNITS_RESET = 16'hFFFF;

  typedef struct packed {
    logic [20:0] accum;
    logic [1:0]  pending;
    logic [15:0] units_out;
    logic        stopped;
  } dec_state_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_unit;
    logic        done_res;
    logic        truncated;
  } result_t;

endpackage

@@ rtl/core/u8u16_decode.sv @@
// Single-pass decode of one byte against the string state into up to two results.
module u8u16_decode (
  input  logic [7:0]            byte_q,
  input  u8u16_pkg::dec_state_t st,
  input  logic [15:0]           max_units,
  output u8u16_pkg::dec_state_t st_next,
  output logic [1:0]            res_count,
  output u8u16_pkg::result_t    res0,
  output u8u16_pkg::result_t    res1
);

  logic        is_cont;
  logic        is_ascii;
  logic        is_lead2;
  logic        is_lead3;
  logic        is_lead4;
  logic        lead_emit;
  logic [15:0] lead_val;
  logic [20:0] lead_accum;
  logic [1:0]  lead_pend;
  logic [20:0] acc_shift;

  logic        en1;
  logic [20:0] v1;
  logic        en2;
  logic [15:0] v2;
  logic        is_done;
  logic        need2;
  logic [16:0] cap1;
  logic        fit1;
  logic        stop1;
  logic [15:0] units1;
  logic [16:0] cap2;
  logic        fit2;
  logic        stop2;
  logic [15:0] units2;
  logic [19:0] v_off;
  u8u16_pkg::result_t list [4];
  logic [2:0]  cnt;

  assign is_cont  = (byte_q & u8u16_pkg::MASK_CONT) == u8u16_pkg::CODE_CONT;
  assign is_ascii = !byte_q[7];
  assign is_lead2 = (byte_q & u8u16_pkg::MASK_LEAD2) == u8u16_pkg::CODE_LEAD2;
  assign is_lead3 = (byte_q & u8u16_pkg::MASK_LEAD3) == u8u16_pkg::CODE_LEAD3;
  assign is_lead4 = (byte_q & u8u16_pkg::MASK_LEAD4) == u8u16_pkg::CODE_LEAD4;
  assign acc_shift = {st.accum[14:0], byte_q[5:0]};

  always_comb begin
    lead_emit  = 1'b0;
    lead_val   = u8u16_pkg::REPL_UNIT;
    lead_accum = '0;
    lead_pend  = 2'd0;
    if (is_ascii) begin
      lead_emit = 1'b1;
      lead_val  = {8'h00, byte_q};
    end else if (is_lead2) begin
      lead_accum = {16'h0000, byte_q[4:0]};
      lead_pend  = 2'd1;
    end else if (is_lead3) begin
      lead_accum = {17'h00000, byte_q[3:0]};
      lead_pend  = 2'd2;
    end else if (is_lead4) begin
      lead_accum = {18'h00000, byte_q[2:0]};
      lead_pend  = 2'd3;
    end else begin
      lead_emit = 1'b1;
    end
  end

  // Select what the byte asks to emit and the sequence state it leaves.
  always_comb begin
    en1     = 1'b0;
    v1      = {5'h00, u8u16_pkg::REPL_UNIT};
    en2     = 1'b0;
    v2      = lead_val;
    is_done = 1'b0;
    st_next = st;
    if (byte_q == 8'h00) begin
      is_done = 1'b1;
      en1     = st.pending != 2'd0;
    end else if (st.stopped) begin
      st_next = st;
    end else if (st.pending != 2'd0 && is_cont) begin
      if (st.pending == 2'd1) begin
        en1 = 1'b1;
        v1  = (acc_shift > u8u16_pkg::MAX_SCALAR) ?
              {5'h00, u8u16_pkg::REPL_UNIT} : acc_shift;
        st_next.accum   = '0;
        st_next.pending = 2'd0;
      end else begin
        st_next.accum   = acc_shift;
        st_next.pending = st.pending - 2'd1;
      end
    end else if (st.pending != 2'd0) begin
      en1 = 1'b1;
      en2 = lead_emit;
      st_next.accum   = lead_accum;
      st_next.pending = lead_pend;
    end else begin
      en1 = lead_emit;
      v1  = {5'h00, lead_val};
      st_next.accum   = lead_accum;
      st_next.pending = lead_pend;
    end

    need2  = v1 > u8u16_pkg::BMP_MAX;
    cap1   = {1'b0, st.units_out} + (need2 ? 17'd2 : 17'd1);
    fit1   = en1 && !st.stopped && (cap1 <= {1'b0, max_units});
    stop1  = st.stopped || (en1 && !fit1);
    units1 = fit1 ? cap1[15:0] : st.units_out;
    cap2   = {1'b0, units1} + 17'd1;
    fit2   = en2 && !stop1 && (cap2 <= {1'b0, max_units});
    stop2  = stop1 || (en2 && !fit2);
    units2 = fit2 ? cap2[15:0] : units1;

    // An interrupting lead that opens a sequence is dropped once output stops.
    if (byte_q != 8'h00 && !st.stopped && st.pending != 2'd0 && !is_cont && stop1) begin
      st_next.accum   = '0;
      st_next.pending = 2'd0;
    end

    if (is_done) begin
      st_next.accum     = '0;
      st_next.pending   = 2'd0;
      st_next.units_out = '0;
      st_next.stopped   = 1'b0;
    end else begin
      st_next.units_out = units2;
      st_next.stopped   = stop2;
    end
  end

  // Pack the emitted units and the done marker in order.
  always_comb begin
    v_off = v1[19:0] - u8u16_pkg::PLANE_BASE[19:0];
    for (int i = 0; i < 4; i++) begin
      list[i] = '0;
    end
    cnt = 3'd0;
    if (fit1) begin
      if (need2) begin
        list[0] = '{code_unit: u8u16_pkg::HI_SURR + {6'h00, v_off[19:10]},
                    has_unit: 1'b1, done_res: 1'b0, truncated: 1'b0};
        list[1] = '{code_unit: u8u16_pkg::LO_SURR + {6'h00, v_off[9:0]},
                    has_unit: 1'b1, done_res: 1'b0, truncated: 1'b0};
        cnt = 3'd2;
      end else begin
        list[0] = '{code_unit: v1[15:0], has_unit: 1'b1, done_res: 1'b0,
                    truncated: 1'b0};
        cnt = 3'd1;
      end
    end
    if (fit2) begin
      list[cnt[1:0]] = '{code_unit: v2, has_unit: 1'b1, done_res: 1'b0,
                         truncated: 1'b0};
      cnt = cnt + 3'd1;
    end
    if (is_done) begin
      list[cnt[1:0]] = '{code_unit: 16'h0000, has_unit: 1'b0, done_res: 1'b1,
                         truncated: stop1};
      cnt = cnt + 3'd1;
    end
    res0      = list[0];
    res1      = list[1];
    res_count = cnt[1:0];
  end

endmodule

@@ rtl/core/u8u16_outq.sv @@
// Four-entry result queue: takes up to two results a cycle, gives one unless stalled.
module u8u16_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         push_count,
  input  u8u16_pkg::result_t push0,
  input  u8u16_pkg::result_t push1,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output u8u16_pkg::result_t head
);

  u8u16_pkg::result_t entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic       pop;

  assign out_valid = count != 3'd0;
  assign room      = count <= 3'd2;
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];
  assign count_next = count + {1'b0, push_count} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

endmodule

@@ rtl/core/utf8_to_utf16_decoder.sv @@
// A byte is held in the input register until the result queue has room for its results.
// Throughput: one byte per cycle while the result queue has room; a byte may yield two results,
// and the four-entry result queue absorbs them, stalling the input when it holds more than two.
// Reset (rst, synchronous): clears string state and queue, and sets max_units to 65535.
// Top level of the UTF-8 to UTF-16 decoder: input register, string state and config.
module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic        has_unit,
  output logic        done_res,
  output logic        truncated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [7:0]  byte_q;
  logic        byte_q_valid;
  logic [15:0] max_units;
  logic        room;
  logic        advance;
  logic        load;
  logic [1:0]  res_count;
  logic [1:0]  push_count;
  u8u16_pkg::dec_state_t st;
  u8u16_pkg::dec_state_t st_next;
  u8u16_pkg::result_t    res0;
  u8u16_pkg::result_t    res1;
  u8u16_pkg::result_t    head;

  assign cfg_ready  = 1'b1;
  assign advance    = byte_q_valid && room;
  assign in_stall   = byte_q_valid && !room;
  assign load       = in_valid && !in_stall;
  assign push_count = advance ? res_count : 2'd0;

  assign code_unit = head.code_unit;
  assign has_unit  = head.has_unit;
  assign done_res  = head.done_res;
  assign truncated = head.truncated;

  always_ff @(posedge clk) begin
    if (load) begin
      byte_q <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_q_valid <= 1'b0;
      max_units    <= u8u16_pkg::MAX_UNITS_RESET;
      st           <= '0;
    end else begin
      if (load) begin
        byte_q_valid <= 1'b1;
      end else if (advance) begin
        byte_q_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        max_units <= cfg_data;
      end
      if (advance) begin
        st <= st_next;
      end
    end
  end

  u8u16_decode u_decode (
    .byte_q    (byte_q),
    .st        (st),
    .max_units (max_units),
    .st_next   (st_next),
    .res_count (res_count),
    .res0      (res0),
    .res1      (res1)
  );

  u8u16_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .head       (head)
  );

endmodule

@@ rtl/core/u8u16_checker.sv @@
// Port-level checks for the UTF-8 to UTF-16 decoder and their binding.
module u8u16_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] code_unit,
  input logic        has_unit,
  input logic        done_res,
  input logic        truncated
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Result item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(code_unit) && $stable(done_res))
    else $error("Stalled result item changed.");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !has_unit && code_unit == 16'h0000)
    else $error("Done item carries a code unit.");

  a_trunc_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> !truncated)
    else $error("Truncation flag outside a done item.");

  a_stall_needs_results: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("Input stalled while no result item is waiting.");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (.*);
